// ===== design/lat_pkg.sv =====
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and codes for the live allocation tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  // Event operation codes; codes from four upwards leave the table and the per-op counters unchanged.
  localparam logic [3:0] OP_MALLOC  = 4'd0;
  localparam logic [3:0] OP_FREE    = 4'd1;
  localparam logic [3:0] OP_REALLOC = 4'd2;
  localparam logic [3:0] OP_CALLOC  = 4'd3;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [63:0] addr;
    logic [63:0] bytes;
    logic [31:0] order;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

`default_nettype wire

// ===== design/live_allocation_tracker_top.sv =====
// ----------------------------------------------------------------------------
// live_allocation_tracker_top
// Tracks live heap blocks from a stream of allocator trace events.
// ----------------------------------------------------------------------------
// Each accepted item is one allocator event. The slot table sits in a
// single-port-read memory that is scanned one slot per clock: the scan finds
// the most recently inserted valid entry with the event's address and the
// lowest free slot, then the update state writes the table and the counters
// and loads the result register. No new item is accepted until that update
// has loaded the result. After reset a clearing pass marks every slot free,
// during which no item is accepted. A result waiting in the output register
// holds the next update but not the scan.
`default_nettype none

module live_allocation_tracker_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  event_op_i,
  input  wire logic [63:0] block_addr_i,
  input  wire logic [63:0] block_bytes_i,
  input  wire logic [63:0] stamp_ns_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             matched_o,
  output logic [63:0]      released_bytes_o,
  output logic             dropped_o,
  output logic [6:0]       live_count_o,
  output logic [63:0]      live_total_o,
  output logic [63:0]      malloc_total_o,
  output logic [63:0]      calloc_total_o,
  output logic [63:0]      realloc_new_total_o,
  output logic [63:0]      freed_total_o,
  output logic [63:0]      op_seen_o,
  output logic [63:0]      span_ns_o
);
  import lat_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW:0] CNT_END  = (IW+1)'(TABLE_DEPTH);
  localparam logic [IW:0] CNT_LAST = (IW+1)'(TABLE_DEPTH - 1);

  // Slot memory.
  entry_t mem [TABLE_DEPTH];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          rd_en;
  entry_t        rd_data_q;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q;

  state_e state_q, state_d;
  logic [IW:0] cnt_q, cnt_d;

  // Latched item.
  logic [3:0]  op_q;
  logic [63:0] addr_q, bytes_q, stamp_q;

  // Scan results.
  logic          found_q, found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [31:0]   best_age_q, best_age_d;
  logic [63:0]   best_bytes_q, best_bytes_d;
  logic          free_found_q, free_found_d;
  logic [IW-1:0] free_idx_q, free_idx_d;

  // Running state.
  logic [31:0]   seq_q, seq_d;
  logic [63:0]   op_cnt_q [4];
  logic [63:0]   op_cnt_d [4];
  logic [63:0]   malloc_q, malloc_d, calloc_q, calloc_d;
  logic [63:0]   rnew_q, rnew_d, freed_q, freed_d;
  logic [CW-1:0] live_blk_q, live_blk_d;
  logic [63:0]   live_sum_q, live_sum_d;
  logic [63:0]   first_q, first_d, last_q, last_d;

  logic out_valid_q, out_valid_d, out_load;

  // Update-cycle decode.
  logic        is_ins_op, is_rm_op, do_remove, do_insert, ins_ok, drop;
  logic        known_op;
  logic [63:0] op_next, span;
  logic [31:0] age;
  logic [CW+6:0] live_blk_ext;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    is_ins_op = (op_q == OP_MALLOC) || (op_q == OP_CALLOC);
    is_rm_op  = (op_q == OP_FREE) || (op_q == OP_REALLOC);
    known_op  = (op_q[3:2] == 2'b00);
    do_remove = is_rm_op && found_q;
    do_insert = is_ins_op || ((op_q == OP_REALLOC) && !found_q);
    ins_ok    = do_insert && free_found_q;
    drop      = do_insert && !free_found_q;
    op_next   = op_cnt_q[op_q[1:0]] + 64'd1;
    age       = seq_q - rd_data_q.order;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_en        = 1'b0;
    rd_vld_d     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[IW-1:0];
    mem_wdata    = '0;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    best_bytes_d = best_bytes_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    seq_d        = seq_q;
    op_cnt_d     = op_cnt_q;
    malloc_d     = malloc_q;
    calloc_d     = calloc_q;
    rnew_d       = rnew_q;
    freed_d      = freed_q;
    live_blk_d   = live_blk_q;
    live_sum_d   = live_sum_q;
    first_d      = first_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_load     = 1'b0;
    span         = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + (IW+1)'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          found_d      = 1'b0;
          free_found_d = 1'b0;
          cnt_d        = '0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q != CNT_END) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + (IW+1)'(1);
        end
        if (rd_vld_q) begin
          if (rd_data_q.valid && (rd_data_q.addr == addr_q)) begin
            if (!found_q || (age < best_age_q)) begin
              found_d      = 1'b1;
              best_idx_d   = rd_idx_q;
              best_age_d   = age;
              best_bytes_d = rd_data_q.bytes;
            end
          end
          if (!rd_data_q.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
        end
        if ((cnt_q == CNT_END) && !rd_vld_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          cnt_d       = '0;
          first_d     = (first_q == 64'd0) ? stamp_q : first_q;
          last_d      = stamp_q;
          if ((first_d != 64'd0) && (stamp_q != 64'd0) && (stamp_q >= first_d)) begin
            span = stamp_q - first_d;
          end
          if (known_op) begin
            op_cnt_d[op_q[1:0]] = op_next;
          end
          if (op_q == OP_MALLOC) malloc_d = malloc_q + bytes_q;
          if (op_q == OP_CALLOC) calloc_d = calloc_q + bytes_q;
          if ((op_q == OP_REALLOC) && !found_q) rnew_d = rnew_q + bytes_q;
          if (do_remove) begin
            // Only the valid flag matters once a slot is released.
            freed_d      = freed_q + best_bytes_q;
            live_sum_d   = live_sum_q - best_bytes_q;
            live_blk_d   = live_blk_q - CW'(1);
            mem_we       = 1'b1;
            mem_waddr    = best_idx_q;
            mem_wdata    = '0;
          end else if (ins_ok) begin
            seq_d           = seq_q + 32'd1;
            live_sum_d      = live_sum_q + bytes_q;
            live_blk_d      = live_blk_q + CW'(1);
            mem_we          = 1'b1;
            mem_waddr       = free_idx_q;
            mem_wdata.valid = 1'b1;
            mem_wdata.addr  = addr_q;
            mem_wdata.bytes = bytes_q;
            mem_wdata.order = seq_q + 32'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[cnt_q[IW-1:0]];
      rd_idx_q  <= cnt_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      seq_q        <= '0;
      op_cnt_q     <= '{default: '0};
      malloc_q     <= '0;
      calloc_q     <= '0;
      rnew_q       <= '0;
      freed_q      <= '0;
      live_blk_q   <= '0;
      live_sum_q   <= '0;
      first_q      <= '0;
      last_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      seq_q        <= seq_d;
      op_cnt_q     <= op_cnt_d;
      malloc_q     <= malloc_d;
      calloc_q     <= calloc_d;
      rnew_q       <= rnew_d;
      freed_q      <= freed_d;
      live_blk_q   <= live_blk_d;
      live_sum_q   <= live_sum_d;
      first_q      <= first_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    best_bytes_q <= best_bytes_d;
    free_idx_q   <= free_idx_d;
    if (in_valid_i && in_ready_o) begin
      op_q    <= event_op_i;
      addr_q  <= block_addr_i;
      bytes_q <= block_bytes_i;
      stamp_q <= stamp_ns_i;
    end
  end

  assign live_blk_ext = {7'd0, live_blk_d};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      matched_o           <= do_remove;
      released_bytes_o    <= do_remove ? best_bytes_q : 64'd0;
      dropped_o           <= drop;
      live_count_o        <= live_blk_ext[6:0];
      live_total_o        <= live_sum_d;
      malloc_total_o      <= malloc_d;
      calloc_total_o      <= calloc_d;
      realloc_new_total_o <= rnew_d;
      freed_total_o       <= freed_d;
      op_seen_o           <= known_op ? op_next : 64'd0;
      span_ns_o           <= span;
    end
  end

endmodule

`default_nettype wire
